// ----- src/stvk_pkg.sv -----
`timescale 1ns / 1ps

package stvk_pkg;

  typedef logic [63:0] word_t;

  typedef struct packed {
    logic signed [31:0] f_00;
    logic signed [31:0] f_01;
    logic signed [31:0] f_10;
    logic signed [31:0] f_11;
    logic signed [31:0] f_20;
    logic signed [31:0] f_21;
    logic signed [31:0] grad_0;
    logic signed [31:0] grad_1;
    logic [30:0]        rest_area;
  } hv_in_t;

  typedef struct packed {
    logic signed [63:0] h_00;
    logic signed [63:0] h_01;
    logic signed [63:0] h_02;
    logic signed [63:0] h_11;
    logic signed [63:0] h_12;
    logic signed [63:0] h_22;
    logic               nonsingular;
    logic               saturated;
  } hv_out_t;

  typedef struct packed {
    logic  neg;
    word_t p00;
    word_t p01;
    word_t p10;
    word_t p11;
  } pp_t;

  typedef struct packed {
    logic  sat;
    word_t v;
  } res_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

  localparam word_t Q24_ONE   = 64'h0000_0000_0100_0000;
  localparam word_t WORD_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam word_t WORD_MIN  = 64'h8000_0000_0000_0000;

  // symmetric entry order: 00 01 02 11 12 22
  localparam int unsigned PAIR_I [6] = '{0, 0, 0, 1, 1, 2};
  localparam int unsigned PAIR_J [6] = '{0, 1, 2, 1, 2, 2};
  localparam int unsigned DIAG_P [3] = '{0, 3, 5};
  localparam logic [5:0]  DIAG_MASK  = 6'b101001;

  function automatic word_t sx32(logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic pp_t mul_pp(word_t a, word_t b);
    word_t ua;
    word_t ub;
    pp_t   r;
    ua    = a[63] ? (64'd0 - a) : a;
    ub    = b[63] ? (64'd0 - b) : b;
    r.neg = a[63] ^ b[63];
    r.p00 = 64'(ua[31:0]) * 64'(ub[31:0]);
    r.p01 = 64'(ua[31:0]) * 64'(ub[63:32]);
    r.p10 = 64'(ua[63:32]) * 64'(ub[31:0]);
    r.p11 = 64'(ua[63:32]) * 64'(ub[63:32]);
    return r;
  endfunction

  function automatic res_t mul_fin(pp_t pp, int unsigned sh);
    logic [127:0] prod;
    logic [127:0] q;
    logic [127:0] msk;
    res_t         r;
    prod = {64'd0, pp.p00} + {32'd0, pp.p01, 32'd0} + {32'd0, pp.p10, 32'd0}
         + {pp.p11, 64'd0};
    q    = prod >> sh;
    msk  = (128'd1 << sh) - 128'd1;
    if (pp.neg && ((prod & msk) != 128'd0)) begin
      q = q + 128'd1;
    end
    if (pp.neg) begin
      r.sat = (q[127:64] != 64'd0) || (q[63:0] > WORD_MIN);
      r.v   = r.sat ? WORD_MIN : (64'd0 - q[63:0]);
    end else begin
      r.sat = (q[127:64] != 64'd0) || q[63];
      r.v   = r.sat ? WORD_MAX : q[63:0];
    end
    return r;
  endfunction

  function automatic res_t sadd(word_t a, word_t b);
    word_t s;
    res_t  r;
    s     = a + b;
    r.sat = 1'b0;
    r.v   = s;
    if (!a[63] && !b[63] && s[63]) begin
      r.sat = 1'b1;
      r.v   = WORD_MAX;
    end else if (a[63] && b[63] && !s[63]) begin
      r.sat = 1'b1;
      r.v   = WORD_MIN;
    end
    return r;
  endfunction

  function automatic res_t ssub(word_t a, word_t b);
    word_t s;
    res_t  r;
    s     = a - b;
    r.sat = 1'b0;
    r.v   = s;
    if (!a[63] && b[63] && s[63]) begin
      r.sat = 1'b1;
      r.v   = WORD_MAX;
    end else if (a[63] && !b[63] && !s[63]) begin
      r.sat = 1'b1;
      r.v   = WORD_MIN;
    end
    return r;
  endfunction

  function automatic res_t fin_add2(pp_t x, pp_t y, int unsigned sh);
    res_t rx;
    res_t ry;
    res_t rs;
    rx     = mul_fin(x, sh);
    ry     = mul_fin(y, sh);
    rs     = sadd(rx.v, ry.v);
    rs.sat = rs.sat | rx.sat | ry.sat;
    return rs;
  endfunction

  function automatic res_t fin_add3(pp_t x, pp_t y, pp_t z, int unsigned sh);
    res_t rxy;
    res_t rz;
    res_t rs;
    rxy    = fin_add2(x, y, sh);
    rz     = mul_fin(z, sh);
    rs     = sadd(rxy.v, rz.v);
    rs.sat = rs.sat | rxy.sat | rz.sat;
    return rs;
  endfunction

endpackage

// ----- src/stvk_det.sv -----
`timescale 1ns / 1ps

module stvk_det (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  stvk_pkg::word_t  h_i [6],
  input  logic             sat_i,
  input  logic [62:0]      thr_i,
  output logic             valid_o,
  output stvk_pkg::hv_out_t out_o
);
  import stvk_pkg::*;

  logic [4:0] vld_q;

  pp_t   mp1_d [6];
  pp_t   mp1_q [6];
  word_t h1_q [6];
  logic  sat1_q;

  word_t mn2_d [3];
  word_t mn2_q [3];
  word_t h2_q [6];
  logic  sat2_q;

  pp_t   dp3_d [3];
  pp_t   dp3_q [3];
  word_t h3_q [6];
  logic  sat3_q;

  word_t dt4_d [3];
  word_t dt4_q [3];
  word_t h4_q [6];
  logic  sat4_q;

  hv_out_t out_d;
  hv_out_t out_q;

  res_t  ra;
  res_t  rb;
  res_t  rc;
  res_t  rd;
  res_t  re;
  res_t  rf;
  word_t dmag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_comb begin
    mp1_d[0] = mul_pp(h_i[3], h_i[5]);
    mp1_d[1] = mul_pp(h_i[4], h_i[4]);
    mp1_d[2] = mul_pp(h_i[1], h_i[5]);
    mp1_d[3] = mul_pp(h_i[4], h_i[2]);
    mp1_d[4] = mul_pp(h_i[1], h_i[4]);
    mp1_d[5] = mul_pp(h_i[3], h_i[2]);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ra       = mul_fin(mp1_q[2*k], 24);
      rb       = mul_fin(mp1_q[2*k+1], 24);
      rc       = ssub(ra.v, rb.v);
      mn2_d[k] = rc.v;
    end
  end

  always_comb begin
    dp3_d[0] = mul_pp(h2_q[0], mn2_q[0]);
    dp3_d[1] = mul_pp(h2_q[1], mn2_q[1]);
    dp3_d[2] = mul_pp(h2_q[2], mn2_q[2]);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd       = mul_fin(dp3_q[k], 24);
      dt4_d[k] = rd.v;
    end
  end

  always_comb begin
    re   = ssub(dt4_q[0], dt4_q[1]);
    rf   = sadd(re.v, dt4_q[2]);
    dmag = rf.v[63] ? (64'd0 - rf.v) : rf.v;
    out_d.h_00        = h4_q[0];
    out_d.h_01        = h4_q[1];
    out_d.h_02        = h4_q[2];
    out_d.h_11        = h4_q[3];
    out_d.h_12        = h4_q[4];
    out_d.h_22        = h4_q[5];
    out_d.nonsingular = dmag > {1'b0, thr_i};
    out_d.saturated   = sat4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mp1_q  <= mp1_d;
      h1_q   <= h_i;
      sat1_q <= sat_i;
      mn2_q  <= mn2_d;
      h2_q   <= h1_q;
      sat2_q <= sat1_q;
      dp3_q  <= dp3_d;
      h3_q   <= h2_q;
      sat3_q <= sat2_q;
      dt4_q  <= dt4_d;
      h4_q   <= h3_q;
      sat4_q <= sat3_q;
      out_q  <= out_d;
    end
  end

  assign valid_o = vld_q[4];
  assign out_o   = out_q;

endmodule

// ----- src/stvk_vertex_hessian_unit.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the output stalls; the multiplies are split into
// 32x32 partial products that are merged at 128 bits.
// Output stalls with out_valid_o high freeze the pipeline, so nothing is lost or repeated.
// Reset clears the pipeline valid flags and the three configuration registers to zero.

module stvk_vertex_hessian_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  stvk_pkg::hv_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output stvk_pkg::hv_out_t                out_data_o,
  input  logic                             cfg_we_i,
  input  logic [stvk_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [62:0]                      cfg_wdata_i
);
  import stvk_pkg::*;

  logic        en;
  logic [31:0] mu_q;
  logic [31:0] lam_q;
  logic [62:0] thr_q;
  word_t       mu_w;
  word_t       mu2_w;
  word_t       lam_w;
  word_t       ml_w;
  logic [11:0] vld_q;

  word_t fx [6];
  word_t gx [2];

  pp_t   fgp1_d [6];
  pp_t   fgp1_q [6];
  pp_t   cp1_d [9];
  pp_t   cp1_q [9];
  pp_t   gp1_d [2];
  pp_t   gp1_q [2];
  pp_t   bp1_d [12];
  pp_t   bp1_q [12];
  word_t g1_q [2];
  word_t a1_q;

  word_t fg2_d [3];
  word_t fg2_q [3];
  word_t c2_d [3];
  word_t c2_q [3];
  word_t gn2_d;
  word_t gn2_q;
  word_t b2_d [6];
  word_t b2_q [6];
  word_t g2_q [2];
  word_t a2_q;
  logic  sat2_d;
  logic  sat2_q;
  res_t  r2;

  word_t e3_d [3];
  word_t e3_q [3];
  word_t tre3_d;
  word_t tre3_q;
  pp_t   mp3_d;
  pp_t   mp3_q;
  pp_t   qp3_d [6];
  pp_t   qp3_q [6];
  word_t b3_q [6];
  word_t g3_q [2];
  word_t a3_q;
  logic  sat3_d;
  logic  sat3_q;
  res_t  r3;

  word_t m4_d;
  word_t m4_q;
  word_t q4_d [6];
  word_t q4_q [6];
  pp_t   sp4_d [3];
  pp_t   sp4_q [3];
  pp_t   lp4_d;
  pp_t   lp4_q;
  word_t b4_q [6];
  word_t g4_q [2];
  word_t a4_q;
  logic  sat4_d;
  logic  sat4_q;
  res_t  r4;

  word_t s5_d [3];
  word_t s5_q [3];
  pp_t   mbp5_d [6];
  pp_t   mbp5_q [6];
  pp_t   mlp5_d [6];
  pp_t   mlp5_q [6];
  word_t g5_q [2];
  word_t a5_q;
  logic  sat5_d;
  logic  sat5_q;
  res_t  r5;

  word_t mb6_d [6];
  word_t mb6_q [6];
  word_t ml6_d [6];
  word_t ml6_q [6];
  pp_t   sgp6_d [4];
  pp_t   sgp6_q [4];
  word_t g6_q [2];
  word_t a6_q;
  logic  sat6_d;
  logic  sat6_q;
  res_t  r6;

  word_t sg7_d [2];
  word_t sg7_q [2];
  word_t in7_d [6];
  word_t in7_q [6];
  word_t ld7_d [3];
  word_t ld7_q [3];
  word_t g7_q [2];
  word_t a7_q;
  logic  sat7_d;
  logic  sat7_q;
  res_t  r7;

  pp_t   gsp8_d [2];
  pp_t   gsp8_q [2];
  word_t in8_q [6];
  word_t ld8_q [3];
  word_t a8_q;
  logic  sat8_q;

  word_t gsg9_d;
  word_t gsg9_q;
  word_t in9_q [6];
  word_t ld9_q [3];
  word_t a9_q;
  logic  sat9_d;
  logic  sat9_q;
  res_t  r9;

  word_t in10_d [6];
  word_t in10_q [6];
  word_t a10_q;
  logic  sat10_d;
  logic  sat10_q;
  res_t  r10a;
  res_t  r10b;

  pp_t   ap11_d [6];
  pp_t   ap11_q [6];
  logic  sat11_q;

  word_t h12_d [6];
  word_t h12_q [6];
  logic  sat12_d;
  logic  sat12_q;
  res_t  r12;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  assign mu_w  = {32'd0, mu_q};
  assign mu2_w = {31'd0, mu_q, 1'b0};
  assign lam_w = {32'd0, lam_q};
  assign ml_w  = mu_w + lam_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q  <= '0;
      lam_q <= '0;
      thr_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHEAR:  mu_q  <= cfg_wdata_i[31:0];
        CFG_LAMBDA: lam_q <= cfg_wdata_i[31:0];
        CFG_THRESH: thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[10:0], in_valid_i};
    end
  end

  // stage 1: partial products of the raw inputs
  always_comb begin
    fx[0] = sx32(in_data_i.f_00);
    fx[1] = sx32(in_data_i.f_01);
    fx[2] = sx32(in_data_i.f_10);
    fx[3] = sx32(in_data_i.f_11);
    fx[4] = sx32(in_data_i.f_20);
    fx[5] = sx32(in_data_i.f_21);
    gx[0] = sx32(in_data_i.grad_0);
    gx[1] = sx32(in_data_i.grad_1);
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 2; k++) begin
        fgp1_d[i*2+k] = mul_pp(fx[i*2+k], gx[k]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      cp1_d[k]   = mul_pp(fx[k*2], fx[k*2]);
      cp1_d[3+k] = mul_pp(fx[k*2], fx[k*2+1]);
      cp1_d[6+k] = mul_pp(fx[k*2+1], fx[k*2+1]);
    end
    for (int k = 0; k < 2; k++) begin
      gp1_d[k] = mul_pp(gx[k], gx[k]);
    end
    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < 2; k++) begin
        bp1_d[p*2+k] = mul_pp(fx[PAIR_I[p]*2+k], fx[PAIR_J[p]*2+k]);
      end
    end
  end

  // stage 2: Fg, C = FtF, |g|^2, B = FFt
  always_comb begin
    sat2_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r2       = fin_add2(fgp1_q[i*2], fgp1_q[i*2+1], 16);
      fg2_d[i] = r2.v;
      sat2_d   = sat2_d | r2.sat;
    end
    for (int c = 0; c < 3; c++) begin
      r2      = fin_add3(cp1_q[c*3], cp1_q[c*3+1], cp1_q[c*3+2], 16);
      c2_d[c] = r2.v;
      sat2_d  = sat2_d | r2.sat;
    end
    r2     = fin_add2(gp1_q[0], gp1_q[1], 16);
    gn2_d  = r2.v;
    sat2_d = sat2_d | r2.sat;
    for (int p = 0; p < 6; p++) begin
      r2      = fin_add2(bp1_q[p*2], bp1_q[p*2+1], 16);
      b2_d[p] = r2.v;
      sat2_d  = sat2_d | r2.sat;
    end
  end

  // stage 3: strain and its trace
  always_comb begin
    sat3_d  = sat2_q;
    r3      = ssub(c2_q[0], Q24_ONE);
    e3_d[0] = {r3.v[63], r3.v[63:1]};
    sat3_d  = sat3_d | r3.sat;
    e3_d[1] = {c2_q[1][63], c2_q[1][63:1]};
    r3      = ssub(c2_q[2], Q24_ONE);
    e3_d[2] = {r3.v[63], r3.v[63:1]};
    sat3_d  = sat3_d | r3.sat;
    r3      = sadd(e3_d[0], e3_d[2]);
    tre3_d  = r3.v;
    sat3_d  = sat3_d | r3.sat;
    mp3_d   = mul_pp(mu_w, gn2_q);
    for (int p = 0; p < 6; p++) begin
      qp3_d[p] = mul_pp(fg2_q[PAIR_I[p]], fg2_q[PAIR_J[p]]);
    end
  end

  // stage 4: m = mu|g|^2, FgFg products
  always_comb begin
    sat4_d = sat3_q;
    r4     = mul_fin(mp3_q, 8);
    m4_d   = r4.v;
    sat4_d = sat4_d | r4.sat;
    for (int p = 0; p < 6; p++) begin
      r4      = mul_fin(qp3_q[p], 24);
      q4_d[p] = r4.v;
      sat4_d  = sat4_d | r4.sat;
    end
    for (int k = 0; k < 3; k++) begin
      sp4_d[k] = mul_pp(mu2_w, e3_q[k]);
    end
    lp4_d = mul_pp(lam_w, tre3_q);
  end

  // stage 5: stress
  always_comb begin
    sat5_d  = sat4_q;
    r5      = fin_add2(sp4_q[0], lp4_q, 8);
    s5_d[0] = r5.v;
    sat5_d  = sat5_d | r5.sat;
    r5      = mul_fin(sp4_q[1], 8);
    s5_d[1] = r5.v;
    sat5_d  = sat5_d | r5.sat;
    r5      = fin_add2(sp4_q[2], lp4_q, 8);
    s5_d[2] = r5.v;
    sat5_d  = sat5_d | r5.sat;
    for (int p = 0; p < 6; p++) begin
      mbp5_d[p] = mul_pp(m4_q, b4_q[p]);
      mlp5_d[p] = mul_pp(ml_w, q4_q[p]);
    end
  end

  // stage 6: m*B and (mu+lambda)*FgFg terms
  always_comb begin
    sat6_d = sat5_q;
    for (int p = 0; p < 6; p++) begin
      r6       = mul_fin(mbp5_q[p], 24);
      mb6_d[p] = r6.v;
      sat6_d   = sat6_d | r6.sat;
      r6       = mul_fin(mlp5_q[p], 8);
      ml6_d[p] = r6.v;
      sat6_d   = sat6_d | r6.sat;
    end
    sgp6_d[0] = mul_pp(s5_q[0], g5_q[0]);
    sgp6_d[1] = mul_pp(s5_q[1], g5_q[1]);
    sgp6_d[2] = mul_pp(s5_q[1], g5_q[0]);
    sgp6_d[3] = mul_pp(s5_q[2], g5_q[1]);
  end

  // stage 7: Sg, off-diagonal sums
  always_comb begin
    sat7_d   = sat6_q;
    r7       = fin_add2(sgp6_q[0], sgp6_q[1], 20);
    sg7_d[0] = r7.v;
    sat7_d   = sat7_d | r7.sat;
    r7       = fin_add2(sgp6_q[2], sgp6_q[3], 20);
    sg7_d[1] = r7.v;
    sat7_d   = sat7_d | r7.sat;
    for (int p = 0; p < 6; p++) begin
      if (DIAG_MASK[p]) begin
        in7_d[p] = mb6_q[p];
      end else begin
        r7       = sadd(mb6_q[p], ml6_q[p]);
        in7_d[p] = r7.v;
        sat7_d   = sat7_d | r7.sat;
      end
    end
    for (int k = 0; k < 3; k++) begin
      ld7_d[k] = ml6_q[DIAG_P[k]];
    end
  end

  always_comb begin
    gsp8_d[0] = mul_pp(g7_q[0], sg7_q[0]);
    gsp8_d[1] = mul_pp(g7_q[1], sg7_q[1]);
  end

  always_comb begin
    r9     = fin_add2(gsp8_q[0], gsp8_q[1], 20);
    gsg9_d = r9.v;
    sat9_d = sat8_q | r9.sat;
  end

  // stage 10: diagonal sums, gSg first
  always_comb begin
    sat10_d = sat9_q;
    in10_d  = in9_q;
    for (int k = 0; k < 3; k++) begin
      r10a              = sadd(gsg9_q, in9_q[DIAG_P[k]]);
      r10b              = sadd(r10a.v, ld9_q[k]);
      in10_d[DIAG_P[k]] = r10b.v;
      sat10_d           = sat10_d | r10a.sat | r10b.sat;
    end
  end

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      ap11_d[p] = mul_pp(a10_q, in10_q[p]);
    end
  end

  always_comb begin
    sat12_d = sat11_q;
    for (int p = 0; p < 6; p++) begin
      r12      = mul_fin(ap11_q[p], 20);
      h12_d[p] = r12.v;
      sat12_d  = sat12_d | r12.sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fgp1_q  <= fgp1_d;
      cp1_q   <= cp1_d;
      gp1_q   <= gp1_d;
      bp1_q   <= bp1_d;
      g1_q    <= gx;
      a1_q    <= {33'd0, in_data_i.rest_area};

      fg2_q   <= fg2_d;
      c2_q    <= c2_d;
      gn2_q   <= gn2_d;
      b2_q    <= b2_d;
      g2_q    <= g1_q;
      a2_q    <= a1_q;
      sat2_q  <= sat2_d;

      e3_q    <= e3_d;
      tre3_q  <= tre3_d;
      mp3_q   <= mp3_d;
      qp3_q   <= qp3_d;
      b3_q    <= b2_q;
      g3_q    <= g2_q;
      a3_q    <= a2_q;
      sat3_q  <= sat3_d;

      m4_q    <= m4_d;
      q4_q    <= q4_d;
      sp4_q   <= sp4_d;
      lp4_q   <= lp4_d;
      b4_q    <= b3_q;
      g4_q    <= g3_q;
      a4_q    <= a3_q;
      sat4_q  <= sat4_d;

      s5_q    <= s5_d;
      mbp5_q  <= mbp5_d;
      mlp5_q  <= mlp5_d;
      g5_q    <= g4_q;
      a5_q    <= a4_q;
      sat5_q  <= sat5_d;

      mb6_q   <= mb6_d;
      ml6_q   <= ml6_d;
      sgp6_q  <= sgp6_d;
      g6_q    <= g5_q;
      a6_q    <= a5_q;
      sat6_q  <= sat6_d;

      sg7_q   <= sg7_d;
      in7_q   <= in7_d;
      ld7_q   <= ld7_d;
      g7_q    <= g6_q;
      a7_q    <= a6_q;
      sat7_q  <= sat7_d;

      gsp8_q  <= gsp8_d;
      in8_q   <= in7_q;
      ld8_q   <= ld7_q;
      a8_q    <= a7_q;
      sat8_q  <= sat7_q;

      gsg9_q  <= gsg9_d;
      in9_q   <= in8_q;
      ld9_q   <= ld8_q;
      a9_q    <= a8_q;
      sat9_q  <= sat9_d;

      in10_q  <= in10_d;
      a10_q   <= a9_q;
      sat10_q <= sat10_d;

      ap11_q  <= ap11_d;
      sat11_q <= sat10_q;

      h12_q   <= h12_d;
      sat12_q <= sat12_d;
    end
  end

  stvk_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q[11]),
    .h_i     (h12_q),
    .sat_i   (sat12_q),
    .thr_i   (thr_q),
    .valid_o (out_valid_o),
    .out_o   (out_data_o)
  );

endmodule

// ----- tb/sv/tb_stvk_vertex_hessian_unit.sv -----
`timescale 1ns / 1ps

module tb_stvk_vertex_hessian_unit;
  import stvk_pkg::*;

  localparam int unsigned LATENCY = 17;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  hv_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  hv_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_SHEAR;
  logic [62:0] cfg_wdata_i = '0;

  logic [31:0] mu_reg = '0;
  logic [31:0] lambda_reg = '0;
  logic [62:0] thresh_reg = '0;

  hv_out_t hessian_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cnt = 0;
  bit rx_idling = 1'b1;
  bit rx_hold_req = 1'b0;
  bit tx_idling = 1'b1;

  stvk_vertex_hessian_unit u_dut (.*);

  always #5 clk_i = ~clk_i;

  // floor(a*b / 2^sh), clipped to signed 64 bits
  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b,
                                                int unsigned sh, inout bit sat);
    logic signed [127:0] p;
    p = ($signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b})) >>> sh;
    if (p > 128'(S64_MAX)) begin
      sat = 1'b1;
      return S64_MAX;
    end
    if (p < $signed({{64{1'b1}}, S64_MIN})) begin
      sat = 1'b1;
      return S64_MIN;
    end
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] fx_add(logic signed [63:0] a, logic signed [63:0] b,
                                                inout bit sat);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(S64_MAX)) begin
      sat = 1'b1;
      return S64_MAX;
    end
    if (s < 65'(S64_MIN)) begin
      sat = 1'b1;
      return S64_MIN;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] fx_sub(logic signed [63:0] a, logic signed [63:0] b,
                                                inout bit sat);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(S64_MAX)) begin
      sat = 1'b1;
      return S64_MAX;
    end
    if (s < 65'(S64_MIN)) begin
      sat = 1'b1;
      return S64_MIN;
    end
    return s[63:0];
  endfunction

  function automatic hv_out_t predict_hessian(hv_in_t x);
    logic signed [63:0] f[3][2], g[2], fg[3], c[2][2], e[2][2], s[2][2], sg[2], h[3][3];
    logic signed [63:0] area, tre, gsg, gn2, m, ml, b, inner, det, m0, m1, m2, mu, lam;
    logic [63:0] dmag;
    bit sat, dsat;
    hv_out_t r;
    sat = 1'b0;
    dsat = 1'b0;
    f[0][0] = x.f_00; f[0][1] = x.f_01; f[1][0] = x.f_10;
    f[1][1] = x.f_11; f[2][0] = x.f_20; f[2][1] = x.f_21;
    g[0] = x.grad_0; g[1] = x.grad_1;
    area = {33'd0, x.rest_area};
    mu = {32'd0, mu_reg};
    lam = {32'd0, lambda_reg};
    for (int i = 0; i < 3; i++)
      fg[i] = fx_add(fx_mul(f[i][0], g[0], 16, sat), fx_mul(f[i][1], g[1], 16, sat), sat);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        c[i][j] = 0;
        for (int k = 0; k < 3; k++)
          c[i][j] = fx_add(c[i][j], fx_mul(f[k][i], f[k][j], 16, sat), sat);
      end
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        e[i][j] = fx_mul(i == j ? fx_sub(c[i][j], 64'sd16777216, sat) : c[i][j], 1, 1, sat);
    tre = fx_add(e[0][0], e[1][1], sat);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        s[i][j] = fx_mul(2 * mu, e[i][j], 8, sat);
        if (i == j) s[i][j] = fx_add(s[i][j], fx_mul(lam, tre, 8, sat), sat);
      end
    for (int i = 0; i < 2; i++)
      sg[i] = fx_add(fx_mul(s[i][0], g[0], 20, sat), fx_mul(s[i][1], g[1], 20, sat), sat);
    gsg = fx_add(fx_mul(g[0], sg[0], 20, sat), fx_mul(g[1], sg[1], 20, sat), sat);
    gn2 = fx_add(fx_mul(g[0], g[0], 16, sat), fx_mul(g[1], g[1], 16, sat), sat);
    m = fx_mul(mu, gn2, 8, sat);
    ml = mu + lam;
    for (int i = 0; i < 3; i++)
      for (int j = i; j < 3; j++) begin
        b = fx_add(fx_mul(f[i][0], f[j][0], 16, sat), fx_mul(f[i][1], f[j][1], 16, sat), sat);
        inner = (i == j) ? gsg : 64'sd0;
        inner = fx_add(inner, fx_mul(m, b, 24, sat), sat);
        inner = fx_add(inner, fx_mul(ml, fx_mul(fg[i], fg[j], 24, sat), 8, sat), sat);
        h[i][j] = fx_mul(area, inner, 20, sat);
        h[j][i] = h[i][j];
      end
    m0 = fx_sub(fx_mul(h[1][1], h[2][2], 24, dsat), fx_mul(h[1][2], h[1][2], 24, dsat), dsat);
    m1 = fx_sub(fx_mul(h[0][1], h[2][2], 24, dsat), fx_mul(h[1][2], h[0][2], 24, dsat), dsat);
    m2 = fx_sub(fx_mul(h[0][1], h[1][2], 24, dsat), fx_mul(h[1][1], h[0][2], 24, dsat), dsat);
    det = fx_sub(fx_mul(h[0][0], m0, 24, dsat), fx_mul(h[0][1], m1, 24, dsat), dsat);
    det = fx_add(det, fx_mul(h[0][2], m2, 24, dsat), dsat);
    dmag = det[63] ? 64'd0 - det : det;
    r.h_00 = h[0][0]; r.h_01 = h[0][1]; r.h_02 = h[0][2];
    r.h_11 = h[1][1]; r.h_12 = h[1][2]; r.h_22 = h[2][2];
    r.nonsingular = dmag > {1'b0, thresh_reg};
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    hv_out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (hessian_q.size() == 0) begin
        report_mismatch("unexpected item", out_data_o.h_00, '0);
      end else begin
        want = hessian_q.pop_front();
        if (out_data_o.h_00 !== want.h_00) report_mismatch("h_00", out_data_o.h_00, want.h_00);
        if (out_data_o.h_01 !== want.h_01) report_mismatch("h_01", out_data_o.h_01, want.h_01);
        if (out_data_o.h_02 !== want.h_02) report_mismatch("h_02", out_data_o.h_02, want.h_02);
        if (out_data_o.h_11 !== want.h_11) report_mismatch("h_11", out_data_o.h_11, want.h_11);
        if (out_data_o.h_12 !== want.h_12) report_mismatch("h_12", out_data_o.h_12, want.h_12);
        if (out_data_o.h_22 !== want.h_22) report_mismatch("h_22", out_data_o.h_22, want.h_22);
        if (out_data_o.nonsingular !== want.nonsingular)
          report_mismatch("nonsingular", 64'(out_data_o.nonsingular), 64'(want.nonsingular));
        if (out_data_o.saturated !== want.saturated)
          report_mismatch("saturated", 64'(out_data_o.saturated), 64'(want.saturated));
      end
    end
  end

  // receiver: random stall bursts, or a long hold on request
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (rx_idling && $urandom_range(3) == 0) begin
        out_stall_i <= 1'b1;
        n = $urandom_range(6, 1);
        repeat (n) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(hv_in_t x);
    int unsigned n;
    if (tx_idling && $urandom_range(4) == 0) begin
      in_valid_i <= 1'b0;
      n = $urandom_range(6, 1);
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= x;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    hessian_q.push_back(predict_hessian(x));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (hessian_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [62:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_SHEAR: mu_reg = v[31:0];
      CFG_LAMBDA: lambda_reg = v[31:0];
      CFG_THRESH: thresh_reg = v;
      default: ;
    endcase
  endtask

  task automatic set_material(logic [31:0] mu, logic [31:0] lam, logic [62:0] th);
    write_reg(CFG_SHEAR, {31'd0, mu});
    write_reg(CFG_LAMBDA, {31'd0, lam});
    write_reg(CFG_THRESH, th);
  endtask

  function automatic logic [31:0] rand_q(int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2097152)) - 1048576);
      2: return 32'($signed($urandom_range(65536)) - 32768);
      default: return 32'($signed($urandom_range(4194304)) - 2097152);
    endcase
  endfunction

  function automatic hv_in_t rand_item();
    hv_in_t x;
    int unsigned mode;
    mode = $urandom_range(7);
    if (mode > 3) mode = 1;
    x.f_00 = rand_q(mode); x.f_01 = rand_q(mode); x.f_10 = rand_q(mode);
    x.f_11 = rand_q(mode); x.f_20 = rand_q(mode); x.f_21 = rand_q(mode);
    x.grad_0 = rand_q(mode); x.grad_1 = rand_q(mode);
    x.rest_area = (mode == 0) ? 31'($urandom()) : 31'($urandom_range(2097152));
    return x;
  endfunction

  function automatic logic [31:0] rand_modulus();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(256);
      default: return $urandom_range(65536);
    endcase
  endfunction

  task automatic test_directed();
    hv_in_t x;
    set_material(32'd256, 32'd512, 63'd0);
    x = '0;
    send_item(x);
    x.f_00 = 32'sd1048576; x.f_11 = 32'sd1048576;
    x.grad_0 = 32'sd1048576; x.grad_1 = 32'sd524288; x.rest_area = 31'd1048576;
    send_item(x);
    x.f_20 = 32'sd1048576;
    send_item(x);
    x = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
          32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF};
    send_item(x);
    x = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7FFFFFFF};
    send_item(x);
    x = '{32'sh80000000, 32'sh7FFFFFFF, 32'shFFFFFFFF, 32'sd1, 32'sh80000000,
          32'sd0, 32'shFFFFFFFF, 32'sh7FFFFFFF, 31'd1};
    send_item(x);
    drain();
    set_material(32'hFFFFFFFF, 32'hFFFFFFFF, 63'h7FFFFFFFFFFFFFFF);
    for (int i = 0; i < 6; i++) send_item(rand_item());
    drain();
    write_reg(CFG_IDX_W'(3), 63'h1234);
    set_material(32'd0, 32'd0, 63'd1);
    for (int i = 0; i < 6; i++) send_item(rand_item());
    drain();
  endtask

  task automatic test_random(int unsigned phases, int unsigned per_phase);
    for (int p = 0; p < phases; p++) begin
      set_material(rand_modulus(), rand_modulus(),
                   $urandom_range(1) ? 63'($urandom_range(1 << 20))
                                     : 63'({$urandom(), $urandom()}));
      for (int i = 0; i < per_phase; i++) send_item(rand_item());
      drain();
    end
  endtask

  task automatic test_backpressure();
    rx_hold_req = 1'b1;
    for (int i = 0; i < 60; i++) send_item(rand_item());
    drain();
  endtask

  task automatic test_full_rate();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    for (int i = 0; i < 200; i++) send_item(rand_item());
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(12, 106);
    test_backpressure();
    test_full_rate();
    if (mismatch_cnt == 0 && hessian_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
